### hw/rtl/first_unique_letter_tracker_defines.svh
// assertion macros for the first unique letter tracker
`ifndef FIRST_UNIQUE_LETTER_TRACKER_DEFINES_SVH
`define FIRST_UNIQUE_LETTER_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FULT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define FULT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hw/rtl/fult_pkg.sv
package fult_pkg;

   localparam int LETTER_W = 5;

   typedef logic [1:0] count_type;

   // saturating occurrence count per letter
   localparam count_type COUNT_NONE = 2'd0;
   localparam count_type COUNT_ONCE = 2'd1;
   localparam count_type COUNT_MANY = 2'd2;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                new_stream;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [LETTER_W-1:0] unique_letter;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic count_rd_item;
      logic update;
      logic queue_rd;
      logic count_rd_head;
      logic pop;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic queue_empty;
      logic head_stale;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/fult_datapath.sv
module fult_datapath import fult_pkg::*; #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(ALPHABET_SIZE - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ALPHABET_SIZE);

   // count memory, entries qualified by valid bits
   count_type           count_mem [ALPHABET_SIZE];
   // order queue, written before it is read
   logic [LETTER_W-1:0] queue_mem [ALPHABET_SIZE];

   logic [ALPHABET_SIZE-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [LETTER_W-1:0]      letter_ff, letter_in;
   logic [LETTER_W-1:0]      head_letter_ff;
   count_type                cnt_rd_ff;
   logic                     cnt_vld_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [IDX_W-1:0] letter_addr;
   logic [IDX_W-1:0] cnt_addr;
   logic             item_in_range;
   logic             head_in_range;
   count_type        cnt_seen;
   logic             item_first;
   logic             enqueue;

   assign letter_addr   = IDX_W'(letter_ff);
   assign cnt_addr      = cmd.count_rd_head ? IDX_W'(head_letter_ff) : letter_addr;
   assign item_in_range = int'(letter_ff) < ALPHABET_SIZE;
   assign head_in_range = int'(head_letter_ff) < ALPHABET_SIZE;
   assign cnt_seen      = cnt_vld_ff ? cnt_rd_ff : COUNT_NONE;
   assign item_first    = (cnt_seen == COUNT_NONE);
   assign enqueue       = cmd.update && item_in_range && item_first && (fill_ff != FULL_FILL);

   always_comb begin
      valid_in  = valid_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      letter_in = letter_ff;
      if (cmd.load) begin
         letter_in = req_data.letter;
         if (req_data.new_stream) begin
            valid_in = '0;
            head_in  = '0;
            tail_in  = '0;
            fill_in  = '0;
         end
      end
      if (cmd.update && item_in_range) begin
         valid_in[letter_addr] = 1'b1;
      end
      if (enqueue) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.found         = (fill_ff != '0);
         rsp_in.unique_letter = (fill_ff != '0) ? head_letter_ff : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff <= letter_in;
      rsp_ff    <= rsp_in;
   end

   // count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.count_rd_item || cmd.count_rd_head) begin
         cnt_rd_ff  <= count_mem[cnt_addr];
         cnt_vld_ff <= valid_ff[cnt_addr];
      end
      if (cmd.update && item_in_range) begin
         count_mem[letter_addr] <= item_first ? COUNT_ONCE : COUNT_MANY;
      end
   end

   // queue memory: write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (enqueue) begin
         queue_mem[tail_ff] <= letter_ff;
      end
      if (cmd.queue_rd) begin
         head_letter_ff <= queue_mem[head_ff];
      end
   end

   assign status.queue_empty = (fill_ff == '0);
   assign status.head_stale  = !head_in_range || (cnt_seen == COUNT_MANY);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/fult_ctrl.sv
module fult_ctrl import fult_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_QREAD,
      ST_CREAD,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.count_rd_item = 1'b1;
            state_in          = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_QREAD;
         end
         ST_QREAD: begin
            if (status.queue_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.queue_rd = 1'b1;
               state_in     = ST_CREAD;
            end
         end
         ST_CREAD: begin
            cmd.count_rd_head = 1'b1;
            state_in          = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.head_stale) begin
               cmd.pop  = 1'b1;
               state_in = ST_QREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### hw/rtl/first_unique_letter_tracker.sv
// a request is taken only when the last result is in the result register;
// the time to a result grows with each stale queue head dropped, and with
// any wait on a stalled result; an empty queue skips the queue head read
// the pace is set by the single read port of the count memory and the queue head loop
// reset: synchronous, clears counts (valid bits), queue pointers and result valid at once
// no clearing pass is needed; new_stream clears valid bits and queue pointers on accept
`include "first_unique_letter_tracker_defines.svh"

module first_unique_letter_tracker import fult_pkg::*; #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic    clock,
   input  logic    reset,
   // request channel: one letter per request
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // result channel: one result per request
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, count read, count update and enqueue, then loop over the queue
   // head until a letter seen once is found or the queue is empty
   fult_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: count memory with valid bits, circular order queue,
   // and the result register that lets the next request in while a result waits
   fult_datapath #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   // the block goes busy right after taking a request
   `FULT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // the queue is never popped when empty
   `FULT_ASSERT_NOW(a_no_pop_empty, cmd.pop, !status.queue_empty)

   // a result is only loaded when the result register can take it
   `FULT_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free)

   // a reported letter lies inside the alphabet
   `FULT_ASSERT_NOW(a_letter_range, rsp_valid && rsp_data.found,
                    int'(rsp_data.unique_letter) < ALPHABET_SIZE)

endmodule
